@@ rtl/core/hpu_pkg.sv @@
package hpu_pkg;

    localparam int DEF_NUM_SECTIONS = 12;
    localparam int DEF_SAMPLE_BITS  = 24;

    // Coefficients are unsigned Q0.18.
    localparam int COEF_FRAC  = 18;
    localparam int COEF_BITS  = 18;
    localparam int COEF_COUNT = 12;

    typedef logic [COEF_BITS-1:0] coef_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DONE
    } state_t;

    // Sections past the end of the table use a zero coefficient and act as plain delays.
    function automatic coef_t coef_q18(input int idx);
        coef_t c;
        c = '0;
        case (idx)
            0:       c = 18'd9616;
            1:       c = 18'd35795;
            2:       c = 18'd71993;
            3:       c = 18'd110923;
            4:       c = 18'd147089;
            5:       c = 18'd177613;
            6:       c = 18'd201783;
            7:       c = 18'd220172;
            8:       c = 18'd233901;
            9:       c = 18'd244198;
            10:      c = 18'd252207;
            11:      c = 18'd258950;
            default: c = '0;
        endcase
        return c;
    endfunction

endpackage

@@ rtl/core/halfband_polyphase_upsampler_2x_core.sv @@
// Inputs are taken one at a time: in_ready is high only while idle, and for each
// input the state memory is read once per allpass section through one shared multiplier.
// A new input is taken while an earlier result still waits in the output register.
// Reset (rst_n, asynchronous, active low) clears control and marks all section state as zero.
module halfband_polyphase_upsampler_2x_core #(
    parameter int NUM_SECTIONS = hpu_pkg::DEF_NUM_SECTIONS,
    parameter int SAMPLE_BITS  = hpu_pkg::DEF_SAMPLE_BITS
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [SAMPLE_BITS-1:0] sample_in,
    input  logic                   in_valid,
    output logic                   in_ready,
    output logic [SAMPLE_BITS-1:0] out_first,
    output logic [SAMPLE_BITS-1:0] out_second,
    output logic                   out_valid,
    input  logic                   out_ready
);

    localparam int STB = SAMPLE_BITS + 2;
    localparam int IW  = $clog2(NUM_SECTIONS);

    hpu_pkg::state_t      state_reg;
    hpu_pkg::state_t      state_next;
    logic [IW:0]          rd_cnt_reg;
    logic [IW:0]          rd_cnt_next;
    logic                 s1_vld_reg;
    logic [IW-1:0]        s1_idx_reg;
    logic [STB-1:0]       path0_reg;
    logic [STB-1:0]       path1_reg;
    logic [STB-1:0]       path0_next;
    logic [STB-1:0]       path1_next;
    logic [SAMPLE_BITS-1:0] out_first_reg;
    logic [SAMPLE_BITS-1:0] out_second_reg;
    logic                 out_valid_reg;
    logic                 out_valid_next;

    logic                 in_fire;
    logic                 rd_en;
    logic                 load_out;
    logic [2*STB-1:0]     rdata;
    logic [STB-1:0]       v_s1;
    logic                 res_vld;
    logic [IW-1:0]        res_idx;
    logic [STB-1:0]       res_v;
    logic [STB-1:0]       res_t;
    logic                 last_done;
    logic [SAMPLE_BITS-1:0] sat_first;
    logic [SAMPLE_BITS-1:0] sat_second;

    hpu_state_ram #(
        .DEPTH (NUM_SECTIONS),
        .AW    (IW),
        .WIDTH (2 * STB)
    ) u_state_ram (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (res_vld),
        .waddr (res_idx),
        .wdata ({res_v, res_t}),
        .re    (rd_en),
        .raddr (rd_cnt_reg[IW-1:0]),
        .rdata (rdata)
    );

    // Section i+2 reaches the first stage in the cycle after section i has updated
    // the same path register, so no forwarding is needed.
    assign v_s1 = s1_idx_reg[0] ? path1_reg : path0_reg;

    hpu_allpass_alu #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .IW          (IW)
    ) u_alu (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_vld      (s1_vld_reg),
        .in_idx      (s1_idx_reg),
        .v           (v_s1),
        .last_input  (rdata[2*STB-1:STB]),
        .last_output (rdata[STB-1:0]),
        .res_vld     (res_vld),
        .res_idx     (res_idx),
        .res_v       (res_v),
        .res_t       (res_t)
    );

    assign in_fire   = in_valid && in_ready;
    assign last_done = res_vld && (res_idx == IW'(NUM_SECTIONS - 1));

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            hpu_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = hpu_pkg::ST_RUN;
                end
            end
            hpu_pkg::ST_RUN:
            begin
                if (last_done)
                begin
                    state_next = hpu_pkg::ST_DONE;
                end
            end
            hpu_pkg::ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = hpu_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = hpu_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready = 1'b0;
        rd_en    = 1'b0;
        load_out = 1'b0;
        unique case (state_reg)
            hpu_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
            end
            hpu_pkg::ST_RUN:
            begin
                rd_en = (rd_cnt_reg < (IW + 1)'(NUM_SECTIONS));
            end
            hpu_pkg::ST_DONE:
            begin
                load_out = !out_valid_reg || out_ready;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        rd_cnt_next = rd_cnt_reg;
        if (in_fire)
        begin
            rd_cnt_next = '0;
        end
        else if (rd_en)
        begin
            rd_cnt_next = rd_cnt_reg + 1'b1;
        end

        path0_next = path0_reg;
        path1_next = path1_reg;
        if (in_fire)
        begin
            path0_next = {{2{sample_in[SAMPLE_BITS-1]}}, sample_in};
            path1_next = {{2{sample_in[SAMPLE_BITS-1]}}, sample_in};
        end
        else if (res_vld)
        begin
            if (res_idx[0])
            begin
                path1_next = res_t;
            end
            else
            begin
                path0_next = res_t;
            end
        end

        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Clamp each path to the sample width.
    always_comb
    begin
        if ((&path0_reg[STB-1:SAMPLE_BITS-1]) || !(|path0_reg[STB-1:SAMPLE_BITS-1]))
        begin
            sat_first = path0_reg[SAMPLE_BITS-1:0];
        end
        else
        begin
            sat_first = path0_reg[STB-1] ? {1'b1, {(SAMPLE_BITS-1){1'b0}}}
                                         : {1'b0, {(SAMPLE_BITS-1){1'b1}}};
        end
        if ((&path1_reg[STB-1:SAMPLE_BITS-1]) || !(|path1_reg[STB-1:SAMPLE_BITS-1]))
        begin
            sat_second = path1_reg[SAMPLE_BITS-1:0];
        end
        else
        begin
            sat_second = path1_reg[STB-1] ? {1'b1, {(SAMPLE_BITS-1){1'b0}}}
                                          : {1'b0, {(SAMPLE_BITS-1){1'b1}}};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= hpu_pkg::ST_IDLE;
            rd_cnt_reg    <= '0;
            s1_vld_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rd_cnt_reg    <= rd_cnt_next;
            s1_vld_reg    <= rd_en;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_idx_reg <= rd_cnt_reg[IW-1:0];
        path0_reg  <= path0_next;
        path1_reg  <= path1_next;
        if (load_out)
        begin
            out_first_reg  <= sat_first;
            out_second_reg <= sat_second;
        end
    end

    assign out_first  = out_first_reg;
    assign out_second = out_second_reg;
    assign out_valid  = out_valid_reg;

endmodule

@@ rtl/core/hpu_state_ram.sv @@
module hpu_state_ram #(
    parameter int DEPTH = hpu_pkg::DEF_NUM_SECTIONS,
    parameter int AW    = $clog2(hpu_pkg::DEF_NUM_SECTIONS),
    parameter int WIDTH = 2 * (hpu_pkg::DEF_SAMPLE_BITS + 2)
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] state_mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;
    logic [DEPTH-1:0] valid_reg;
    logic             rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            state_mem[waddr] <= wdata;
        end
        if (re)
        begin
            rd_data_reg <= state_mem[raddr];
        end
    end

    // An entry that has never been written since reset reads as zero.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (we)
            begin
                valid_reg[waddr] <= 1'b1;
            end
            if (re)
            begin
                rd_valid_reg <= valid_reg[raddr];
            end
        end
    end

    assign rdata = rd_valid_reg ? rd_data_reg : '0;

endmodule

@@ rtl/core/hpu_allpass_alu.sv @@
module hpu_allpass_alu #(
    parameter int SAMPLE_BITS = hpu_pkg::DEF_SAMPLE_BITS,
    parameter int IW          = $clog2(hpu_pkg::DEF_NUM_SECTIONS)
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_vld,
    input  logic [IW-1:0]            in_idx,
    input  logic [SAMPLE_BITS+1:0]   v,
    input  logic [SAMPLE_BITS+1:0]   last_input,
    input  logic [SAMPLE_BITS+1:0]   last_output,
    output logic                     res_vld,
    output logic [IW-1:0]            res_idx,
    output logic [SAMPLE_BITS+1:0]   res_v,
    output logic [SAMPLE_BITS+1:0]   res_t
);

    localparam int STB  = SAMPLE_BITS + 2;
    localparam int DW   = STB + 1;
    localparam int PW   = DW + hpu_pkg::COEF_BITS + 1;
    localparam int RW   = PW - hpu_pkg::COEF_FRAC;
    localparam int SUMW = RW + 1;

    logic signed [DW-1:0]   diff;
    logic signed [hpu_pkg::COEF_BITS:0] coef_s;
    logic signed [PW-1:0]   prod;
    logic signed [PW-1:0]   prod_reg;
    logic [STB-1:0]         li_reg;
    logic [STB-1:0]         v_reg;
    logic [IW-1:0]          idx_reg;
    logic                   vld_reg;
    logic signed [PW-1:0]   biased;
    logic signed [RW-1:0]   rounded;
    logic signed [SUMW-1:0] sum;
    logic                   ovf;

    // First stage: exact difference and product.
    always_comb
    begin
        diff   = $signed({v[STB-1], v}) - $signed({last_output[STB-1], last_output});
        coef_s = $signed({1'b0, hpu_pkg::coef_q18(int'(in_idx))});
        prod   = diff * coef_s;
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod;
        li_reg   <= last_input;
        v_reg    <= v;
        idx_reg  <= in_idx;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= in_vld;
        end
    end

    // Second stage: round to nearest with ties upwards, add, saturate to the state width.
    always_comb
    begin
        biased  = prod_reg + PW'(1 << (hpu_pkg::COEF_FRAC - 1));
        rounded = biased[PW-1:hpu_pkg::COEF_FRAC];
        sum     = {rounded[RW-1], rounded} + SUMW'($signed(li_reg));
        ovf     = !((&sum[SUMW-1:STB-1]) || !(|sum[SUMW-1:STB-1]));
        if (ovf)
        begin
            res_t = sum[SUMW-1] ? {1'b1, {(STB-1){1'b0}}} : {1'b0, {(STB-1){1'b1}}};
        end
        else
        begin
            res_t = sum[STB-1:0];
        end
    end

    assign res_vld = vld_reg;
    assign res_idx = idx_reg;
    assign res_v   = v_reg;

endmodule
